### sv/ffra_pkg.sv
// Shared types, constants and codes of the first-fit range allocator.
// No dependencies; every other file of the block imports this package.
package ffra_pkg;

	// Default pool capacity in slots
	localparam int CAPACITY_DEF = 256;
	// Slots held by one cell of the scan chain
	localparam int SEG_W = 16;
	// Slot position, run length and extent width (pool size tops out at 511)
	localparam int POS_W = 9;
	// Range end width: start plus count
	localparam int HI_W = POS_W + 1;
	localparam int START_W = 8;
	localparam int CNT_W = 9;
	localparam int CMD_W = 2;
	localparam logic [POS_W-1:0] POOL_RST = POS_W'(256);

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLR,
		ST_SCAN,
		ST_MARK,
		ST_DONE
	} state_t;

	// Scan token handed from cell to cell
	typedef struct packed {
		logic             vld;
		logic             found;
		logic [POS_W-1:0] begin_pos;
		logic [POS_W-1:0] run_len;
		logic             any;
		logic [POS_W-1:0] ext;
	} tok_t;

	// Controls broadcast from the sequencer to every cell
	typedef struct packed {
		logic [POS_W-1:0] lim;
		logic [CNT_W-1:0] cnt;
		logic [POS_W-1:0] lo;
		logic [HI_W-1:0]  hi;
		logic             seek;
		logic             probe;
		logic             wr_en;
		logic             wr_set;
		logic             cfg_clr;
		logic [POS_W-1:0] cfg_lim;
	} ctl_t;

endpackage

### sv/ffra_ifs.sv
// Channel interfaces of the first-fit range allocator: request, result
// and pool size write. Depends on ffra_pkg for field widths.
interface ffra_req_if;
	import ffra_pkg::*;
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [START_W-1:0] range_start;
	logic [CNT_W-1:0]   count;
	modport source(output valid, cmd, range_start, count, input ready);
	modport sink(input valid, cmd, range_start, count, output ready);
endinterface

interface ffra_rsp_if;
	import ffra_pkg::*;
	logic               valid;
	logic               ready;
	logic [START_W-1:0] alloc_begin;
	logic [CNT_W-1:0]   alloc_size;
	logic               any_used;
	logic [POS_W-1:0]   used_extent;
	modport source(output valid, alloc_begin, alloc_size, any_used, used_extent, input ready);
	modport sink(input valid, alloc_begin, alloc_size, any_used, used_extent, output ready);
endinterface

interface ffra_cfg_if;
	import ffra_pkg::*;
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] pool_size;
	modport source(output valid, pool_size, input ready);
	modport sink(input valid, pool_size, output ready);
endinterface

### sv/ffra_cell.sv
// One cell of the allocator chain: holds SEG_W bitmap slots, extends the
// scan token by its segment and applies broadcast range writes. Uses ffra_pkg.
module ffra_cell #(
	parameter int BASE     = 0,
	parameter int CAPACITY = ffra_pkg::CAPACITY_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ffra_pkg::ctl_t ctl,
	input  ffra_pkg::tok_t tok_in,
	output ffra_pkg::tok_t tok_out
);
	import ffra_pkg::*;

	logic [SEG_W-1:0] used_q, used_d;
	logic [SEG_W-1:0] inpool, free, busy, inrange;
	logic [POS_W-1:0] len [SEG_W];
	logic             hit;
	logic [POS_W-1:0] hit_begin;
	logic             has_used;
	logic [POS_W-1:0] top_ext;
	tok_t             tok_d, tok_q;

	// Classify each slot against the pool limit and the request range
	always_comb begin
		for (int j = 0; j < SEG_W; j++) begin
			inpool[j]  = (BASE + j < CAPACITY) && (BASE + j < int'(ctl.lim));
			free[j]    = inpool[j] && !used_q[j];
			busy[j]    = inpool[j] && used_q[j];
			inrange[j] = (BASE + j >= int'(ctl.lo)) && (BASE + j < int'(ctl.hi));
		end
	end

	// Length of the free run ending at each slot, carried in from the left
	always_comb begin
		logic blk;
		int   last;
		for (int j = 0; j < SEG_W; j++) begin
			blk  = 1'b0;
			last = 0;
			for (int k = 0; k <= j; k++) begin
				if (!free[k]) begin
					blk  = 1'b1;
					last = k;
				end
			end
			if (!free[j]) begin
				len[j] = '0;
			end else if (blk) begin
				len[j] = POS_W'(j - last);
			end else begin
				len[j] = POS_W'(int'(tok_in.run_len) + j + 1);
			end
		end
	end

	// Pick the lowest slot whose run reaches the requested count
	always_comb begin
		hit       = 1'b0;
		hit_begin = '0;
		for (int j = SEG_W - 1; j >= 0; j--) begin
			if (free[j] && (len[j] >= ctl.cnt)) begin
				hit       = 1'b1;
				hit_begin = POS_W'(BASE + j + 1 - int'(len[j]));
			end
		end
	end

	// Highest used slot of this segment
	always_comb begin
		has_used = 1'b0;
		top_ext  = '0;
		for (int j = 0; j < SEG_W; j++) begin
			if (busy[j]) begin
				has_used = 1'b1;
				top_ext  = POS_W'(BASE + j + 1);
			end
		end
	end

	// Extend the token by this segment
	always_comb begin
		tok_d.vld       = tok_in.vld;
		tok_d.found     = tok_in.found || (ctl.seek && hit);
		tok_d.begin_pos = tok_in.found ? tok_in.begin_pos : hit_begin;
		tok_d.run_len   = len[SEG_W-1];
		tok_d.any       = tok_in.any || (ctl.probe && (|(busy & inrange)));
		tok_d.ext       = has_used ? top_ext : tok_in.ext;
	end

	// Apply resize clears and range set or clear
	always_comb begin
		for (int j = 0; j < SEG_W; j++) begin
			used_d[j] = used_q[j];
			if (ctl.cfg_clr && (BASE + j >= int'(ctl.cfg_lim))) begin
				used_d[j] = 1'b0;
			end else if (ctl.wr_en && inpool[j] && inrange[j]) begin
				used_d[j] = ctl.wr_set;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			tok_q  <= '0;
		end else begin
			used_q <= used_d;
			tok_q  <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

### sv/ffra_ctrl.sv
// Sequencer of the allocator: takes requests and pool size writes, launches
// scan tokens into the cell chain, commits range writes, holds the result.
// Uses ffra_pkg and the channel interfaces.
module ffra_ctrl #(
	parameter int CAPACITY = ffra_pkg::CAPACITY_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	ffra_req_if.sink       req,
	ffra_rsp_if.source     rsp,
	ffra_cfg_if.sink       cfg,
	output ffra_pkg::ctl_t ctl,
	output ffra_pkg::tok_t tok_first,
	input  ffra_pkg::tok_t tok_last
);
	import ffra_pkg::*;

	state_t             state_q, state_d;
	logic               launch_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [START_W-1:0] start_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [POS_W-1:0]   pool_q;
	logic [POS_W-1:0]   lim;
	logic [POS_W-1:0]   res_begin_q;
	logic [CNT_W-1:0]   res_size_q;
	logic               res_any_q;
	logic [POS_W-1:0]   res_ext_q;
	logic               rsp_vld_q;
	logic [START_W-1:0] rsp_begin_q;
	logic [CNT_W-1:0]   rsp_size_q;
	logic               rsp_any_q;
	logic [POS_W-1:0]   rsp_ext_q;
	logic               req_fire, cfg_fire, scan_done, out_load;
	logic [HI_W-1:0]    mark_end;

	// Effective pool size: saturate at capacity
	function automatic logic [POS_W-1:0] lim_of(input logic [POS_W-1:0] v);
		if (int'(v) > CAPACITY) begin
			return POS_W'(CAPACITY);
		end
		return v;
	endfunction

	assign lim       = lim_of(pool_q);
	assign req_fire  = req.valid && req.ready;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign scan_done = (state_q == ST_SCAN) && tok_last.vld;
	assign out_load  = (state_q == ST_DONE) && (!rsp_vld_q || rsp.ready);
	assign mark_end  = HI_W'(tok_last.begin_pos) + HI_W'(cnt_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = (req.cmd == CMD_FREE) ? ST_CLR : ST_SCAN;
				end
			end
			ST_CLR: state_d = ST_SCAN;
			ST_SCAN: begin
				if (tok_last.vld) begin
					state_d = tok_last.found ? ST_MARK : ST_DONE;
				end
			end
			ST_MARK: state_d = ST_DONE;
			ST_DONE: begin
				if (!rsp_vld_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshakes and cell controls
	always_comb begin
		req.ready   = (state_q == ST_IDLE);
		cfg.ready   = 1'b1;
		ctl.lim     = lim;
		ctl.cnt     = cnt_q;
		ctl.seek    = (cmd_q == CMD_ALLOC) && (cnt_q != '0);
		ctl.probe   = (cmd_q == CMD_QUERY);
		ctl.wr_en   = (state_q == ST_CLR) || (state_q == ST_MARK);
		ctl.wr_set  = (state_q == ST_MARK);
		ctl.cfg_clr = cfg_fire;
		ctl.cfg_lim = lim_of(cfg.pool_size);
		if (state_q == ST_MARK) begin
			ctl.lo = res_begin_q;
			ctl.hi = HI_W'(res_begin_q) + HI_W'(cnt_q);
		end else begin
			ctl.lo = POS_W'(start_q);
			ctl.hi = HI_W'(start_q) + HI_W'(cnt_q);
		end
		tok_first.vld       = launch_q;
		tok_first.found     = 1'b0;
		tok_first.begin_pos = '0;
		tok_first.run_len   = '0;
		tok_first.any       = 1'b0;
		tok_first.ext       = '0;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			launch_q  <= 1'b0;
			pool_q    <= POOL_RST;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= (state_q != ST_SCAN) && (state_d == ST_SCAN);
			if (cfg_fire) begin
				pool_q <= cfg.pool_size;
			end
			if (out_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// Hold the request, then the scan outcome, then the result
	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q   <= req.cmd;
			start_q <= req.range_start;
			cnt_q   <= req.count;
		end
		if (scan_done) begin
			res_any_q <= tok_last.any;
			if (tok_last.found) begin
				res_begin_q <= tok_last.begin_pos;
				res_size_q  <= cnt_q;
				res_ext_q   <= (mark_end > HI_W'(tok_last.ext)) ?
					mark_end[POS_W-1:0] : tok_last.ext;
			end else begin
				res_begin_q <= '0;
				res_size_q  <= '0;
				res_ext_q   <= tok_last.ext;
			end
		end
		if (out_load) begin
			rsp_begin_q <= res_begin_q[START_W-1:0];
			rsp_size_q  <= res_size_q;
			rsp_any_q   <= res_any_q;
			rsp_ext_q   <= res_ext_q;
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.alloc_begin = rsp_begin_q;
	assign rsp.alloc_size  = rsp_size_q;
	assign rsp.any_used    = rsp_any_q;
	assign rsp.used_extent = rsp_ext_q;

endmodule

### sv/first_fit_range_allocator_top.sv
// First-fit contiguous slot allocator over a pool bitmap.
// Channels: req carries cmd (allocate, free range, query range), range_start
// and count; rsp returns alloc_begin, alloc_size, any_used and used_extent,
// one result per request; cfg writes pool_size, accepted in any cycle but
// meant to be written only while no request is in flight. A write clears
// the slots at and beyond the new size in that same cycle.
// The bitmap sits in a chain of CAPACITY/16 cells, rounded up, 16 slots
// each. A scan token walks the chain one cell per cycle. Allocate and
// query run one scan; a successful allocate then marks the run. Free
// clears the range, then runs a scan for the new extent. Each request
// ends in the done state, which loads the result register.
// One request is in flight at a time; req.ready is high only between
// requests. The result register decouples rsp: a stalled receiver holds the
// result, the next request is accepted and processed, and it waits for the
// register to empty before its result loads.
// Reset clears the bitmap and sets pool_size to 256.
module first_fit_range_allocator_top #(
	parameter int CAPACITY = ffra_pkg::CAPACITY_DEF
) (
	input logic        clk,
	input logic        arst_n,
	ffra_req_if.sink   req,
	ffra_rsp_if.source rsp,
	ffra_cfg_if.sink   cfg
);
	import ffra_pkg::*;

	localparam int NCELL = (CAPACITY + SEG_W - 1) / SEG_W;

	ctl_t ctl;
	tok_t tok [NCELL+1];

	ffra_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg      (cfg),
		.ctl      (ctl),
		.tok_first(tok[0]),
		.tok_last (tok[NCELL])
	);

	// Chain of bitmap cells, token flows from low slots to high
	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		ffra_cell #(
			.BASE    (g * SEG_W),
			.CAPACITY(CAPACITY)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.tok_in (tok[g]),
			.tok_out(tok[g+1])
		);
	end

endmodule

### sv/ffra_checker.sv
// Port-level checks of the first-fit range allocator, bound to the top level.
// Uses ffra_pkg for field widths.
module ffra_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [ffra_pkg::START_W-1:0] alloc_begin,
	input logic [ffra_pkg::CNT_W-1:0]   alloc_size,
	input logic                         any_used,
	input logic [ffra_pkg::POS_W-1:0]   used_extent
);
	import ffra_pkg::*;

	// Hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(alloc_begin) &&
			$stable(alloc_size) && $stable(any_used) && $stable(used_extent))
		else $error("stalled result changed");

	// Drop ready once a request is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	// A granted size does not exceed the extent
	a_grant_extent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (HI_W'(alloc_size) <= HI_W'(used_extent)))
		else $error("granted size beyond used extent");

	// A used slot implies a nonzero extent
	a_any_extent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && any_used |-> used_extent != '0)
		else $error("used slot reported with empty pool");

endmodule

bind first_fit_range_allocator_top ffra_checker u_ffra_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.alloc_begin(rsp.alloc_begin),
	.alloc_size (rsp.alloc_size),
	.any_used   (rsp.any_used),
	.used_extent(rsp.used_extent)
);
